### hdl/hashed_operation_result_cache_macros.svh
// Assertion macros for the checker file of the result cache.
`ifndef HASHED_OPERATION_RESULT_CACHE_MACROS_SVH
`define HASHED_OPERATION_RESULT_CACHE_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define HOCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles
`define HOCC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/hocc_pkg.sv
// Shared types, constants and hash function of the operation result cache.
package hocc_pkg;

    localparam int DEF_TABLE_SIZE = 4096;
    localparam int CODE_W         = 8;
    localparam int WORD_W         = 32;
    localparam int IN_DATA_W      = 104;
    localparam int IN_USER_W      = 2;
    localparam int OUT_DATA_W     = 32;
    localparam int OUT_USER_W     = 1;

    localparam logic [WORD_W-1:0] HASH_SEED = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] HASH_MULT = 32'd31;

    localparam logic [CODE_W-1:0] CODE_EMPTY = 8'd0;
    localparam logic              OP_LOOKUP  = 1'b0;
    localparam logic              OP_INSERT  = 1'b1;

    // One table slot as it sits in memory
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
        logic [WORD_W-1:0] answer;
    } t_slot;

    // h = h * 31 xor byte, 32-bit wrap
    function automatic logic [WORD_W-1:0] mix_byte(input logic [WORD_W-1:0] h,
                                                   input logic [7:0] b);
        logic [WORD_W-1:0] p;
        p = h * HASH_MULT;
        return p ^ {24'd0, b};
    endfunction

endpackage

### hdl/hocc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module hocc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/hashed_operation_result_cache.sv
// Top level of the hashed operation result cache.
//
// Slave channel: one request per transfer. tuser[0] = op (0 lookup, 1 insert),
// tuser[1] = is_binary. tdata holds operation_code, first_operand,
// second_operand and answer_in. Master channel: one result per request,
// tuser[0] = hit, tdata = answer_out (zero on a miss and for every insert).
//
// Requests are handled one at a time. The key hash takes in up to three
// bytes of the key per cycle. For a table size that is not a power of two
// the home slot comes from a reciprocal multiply, a multiply-subtract and
// one compare-subtract. The three probes are then read back to back from
// the single table memory, an insert adds a write, and the output register
// is loaded last. Code zero skips the table.
//
// After reset the block sweeps the whole table, one slot per cycle, writing
// every code to empty; s_axis tready stays low meanwhile. A stalled master
// side holds its result in the output register; the next request is taken
// and worked on, and waits only to hand over.
module hashed_operation_result_cache #(
    parameter int TABLE_SIZE = hocc_pkg::DEF_TABLE_SIZE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // operation_code[7:0], first_operand[39:8], second_operand[71:40],
    // answer_in[103:72]
    input  logic [hocc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // op[0], is_binary[1]
    input  logic [hocc_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // answer_out[31:0]
    output logic [hocc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // hit[0]
    output logic [hocc_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import hocc_pkg::*;

    localparam int  AW      = $clog2(TABLE_SIZE);
    localparam int  PROD_W  = 2 * WORD_W;
    localparam bit  IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);
    localparam logic [AW:0]   TS_EXT    = (AW+1)'(TABLE_SIZE);
    localparam logic [WORD_W-1:0] TS_WORD = WORD_W'(TABLE_SIZE);
    localparam logic [WORD_W-1:0] RECIP   =
        WORD_W'((64'd1 << WORD_W) / 64'(TABLE_SIZE));

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_PROBE  = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]        r_state;
    logic              r_op;
    logic              r_bin;
    logic [CODE_W-1:0] r_code;
    logic [WORD_W-1:0] r_first;
    logic [WORD_W-1:0] r_second;
    logic [WORD_W-1:0] r_ans_in;
    logic [WORD_W-1:0] r_hash;
    logic [1:0]        r_step;
    logic [1:0]        r_mcnt;
    logic [WORD_W-1:0] r_quo;
    logic [AW:0]       r_rem;
    logic [AW-1:0]     r_home;
    logic [AW-1:0]     r_addr;
    logic [1:0]        r_pcnt;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;
    logic              r_found;
    logic [AW-1:0]     r_tgt;
    logic [WORD_W-1:0] r_hit_ans;
    logic [AW-1:0]     r_clr_addr;
    logic              r_ovalid;
    logic              r_ohit;
    logic [WORD_W-1:0] r_oans;

    logic [WORD_W-1:0] n_hash;
    logic [AW-1:0]     n_rem;
    logic [WORD_W-1:0] w_quo;
    logic [WORD_W-1:0] w_diff;
    logic [7:0]        w_bytes [9];
    logic              w_s_acc;
    logic              w_hash_last;
    logic              w_out_free;
    logic              w_match;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_slot             w_wslot;
    t_slot             w_rslot;
    logic [$bits(t_slot)-1:0] w_rdata;

    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // Key bytes: code, then first and second operand, most significant first
    assign w_bytes[0] = r_code;
    assign w_bytes[1] = r_first[31:24];
    assign w_bytes[2] = r_first[23:16];
    assign w_bytes[3] = r_first[15:8];
    assign w_bytes[4] = r_first[7:0];
    assign w_bytes[5] = r_second[31:24];
    assign w_bytes[6] = r_second[23:16];
    assign w_bytes[7] = r_second[15:8];
    assign w_bytes[8] = r_second[7:0];

    // Up to three hash rounds per cycle
    always_comb begin
        logic [3:0] idx;
        logic [3:0] nbytes;
        n_hash = r_hash;
        nbytes = r_bin ? 4'd9 : 4'd5;
        for (int j = 0; j < 3; j++) begin
            idx = {2'b00, r_step} * 4'd3 + 4'(j);
            if (idx < nbytes) begin
                n_hash = mix_byte(n_hash, w_bytes[idx]);
            end
        end
    end

    assign w_hash_last = (r_step == (r_bin ? 2'd2 : 2'd1));

    // Remainder by table size: the reciprocal quotient is at most one short,
    // so one compare-subtract finishes it
    assign w_quo  = WORD_W'((PROD_W'(r_hash) * PROD_W'(RECIP)) >> WORD_W);
    assign w_diff = r_hash - r_quo * TS_WORD;
    assign n_rem  = (r_rem >= TS_EXT) ? AW'(r_rem - TS_EXT) : r_rem[AW-1:0];

    // Probe compare on the slot read back last cycle
    assign w_rslot = t_slot'(w_rdata);
    assign w_match = (w_rslot.code == r_code) && (w_rslot.first == r_first) &&
                     (!r_bin || (w_rslot.second == r_second));

    // Table write port: clearing sweep or insert
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wslot = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_WRITE: begin
                w_we           = 1'b1;
                w_waddr        = r_found ? r_tgt : r_home;
                w_wslot.code   = r_code;
                w_wslot.first  = r_first;
                w_wslot.second = r_second;
                w_wslot.answer = r_ans_in;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    hocc_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wslot),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // Sequencer: clear, accept, hash, reduce, probe, write, hand over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_SLOT) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_s_acc) begin
                        r_op     <= i_s_axis_tuser[0];
                        r_bin    <= i_s_axis_tuser[1];
                        r_code   <= i_s_axis_tdata[7:0];
                        r_first  <= i_s_axis_tdata[39:8];
                        r_second <= i_s_axis_tuser[1] ? i_s_axis_tdata[71:40] : '0;
                        r_ans_in <= i_s_axis_tdata[103:72];
                        r_hash   <= HASH_SEED;
                        r_step   <= 2'd0;
                        r_found  <= 1'b0;
                        r_state  <= (i_s_axis_tdata[7:0] == CODE_EMPTY) ? ST_FINISH
                                                                        : ST_HASH;
                    end
                end
                ST_HASH: begin
                    r_hash <= n_hash;
                    r_step <= r_step + 1'b1;
                    if (w_hash_last) begin
                        if (IS_POW2) begin
                            r_addr  <= n_hash[AW-1:0];
                            r_home  <= n_hash[AW-1:0];
                            r_pcnt  <= 2'd0;
                            r_state <= ST_PROBE;
                        end else begin
                            r_mcnt  <= 2'd0;
                            r_state <= ST_MOD;
                        end
                    end
                end
                ST_MOD: begin
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd0) begin
                        r_quo <= w_quo;
                    end else if (r_mcnt == 2'd1) begin
                        r_rem <= w_diff[AW:0];
                    end else begin
                        r_addr  <= n_rem;
                        r_home  <= n_rem;
                        r_pcnt  <= 2'd0;
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    r_pcnt <= r_pcnt + 1'b1;
                    if (r_pcnt != 2'd3) begin
                        r_rd_vld  <= 1'b1;
                        r_rd_addr <= r_addr;
                        r_addr    <= (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
                    end
                    // first hit for a lookup, first empty slot for an insert
                    if (r_rd_vld && !r_found) begin
                        if (r_op == OP_LOOKUP && w_match) begin
                            r_found   <= 1'b1;
                            r_hit_ans <= w_rslot.answer;
                        end
                        if (r_op == OP_INSERT && w_rslot.code == CODE_EMPTY) begin
                            r_found <= 1'b1;
                            r_tgt   <= r_rd_addr;
                        end
                    end
                    if (r_pcnt == 2'd3) begin
                        r_state <= (r_op == OP_INSERT) ? ST_WRITE : ST_FINISH;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_FINISH && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && w_out_free) begin
            r_ohit <= (r_op == OP_LOOKUP) && r_found;
            r_oans <= ((r_op == OP_LOOKUP) && r_found) ? r_hit_ans : '0;
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_oans;
    assign o_m_axis_tuser[0] = r_ohit;

endmodule

### hdl/hocc_checker.sv
// Port-level checks of the result cache and their binding to the top level.
`include "hashed_operation_result_cache_macros.svh"

module hocc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [hocc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [hocc_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);

    // Reset empties the output and starts the clearing sweep
    `HOCC_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready, "output or input live right after reset")

    // Requests are serviced one at a time: no transfer right after another
    `HOCC_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "request taken while one is in service")

    // A miss or an insert result carries a zero answer
    `HOCC_ASSERT(a_miss_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0, "nonzero answer without a hit")

    // A stalled result holds
    `HOCC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

endmodule

bind hashed_operation_result_cache hocc_checker u_hocc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### dv/hashed_operation_result_cache_tb.sv
// Testbench for the hashed operation result cache: a mirrored table predicts every result.
`timescale 1ns / 100ps

module hashed_operation_result_cache_tb;
    import hocc_pkg::*;

    localparam int unsigned SLOTS       = DEF_TABLE_SIZE;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_ITEMS  = 1700;
    localparam int          CYCLE_LIMIT = 400000;

    // One request as the sender sees it
    typedef struct {
        logic              op;
        logic              bin;
        logic [CODE_W-1:0] code;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] ans;
    } t_cache_req;

    // One result as the receiver sees it
    typedef struct {
        logic              hit;
        logic [WORD_W-1:0] answer;
    } t_cache_res;

    // Mirror of the slot table plus the results still owed by the block
    class cache_mirror;
        logic [CODE_W-1:0] code_tab   [SLOTS];
        logic [WORD_W-1:0] first_tab  [SLOTS];
        logic [WORD_W-1:0] second_tab [SLOTS];
        logic [WORD_W-1:0] answer_tab [SLOTS];
        t_cache_res        awaited_results [$];
        int                mismatches;

        function new();
            foreach (code_tab[i]) begin
                code_tab[i]   = CODE_EMPTY;
                first_tab[i]  = '0;
                second_tab[i] = '0;
                answer_tab[i] = '0;
            end
            mismatches = 0;
        endfunction

        // Home slot: h = h * 31 xor byte over code, then operands MSB first
        static function int unsigned home_of(logic bin, logic [CODE_W-1:0] code,
                                             logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            logic [WORD_W-1:0] h;
            int                i;
            h = HASH_SEED;
            h = (h * 32'd31) ^ {24'd0, code};
            for (i = 3; i >= 0; i--)
                h = (h * 32'd31) ^ {24'd0, a[8*i +: 8]};
            if (bin) begin
                for (i = 3; i >= 0; i--)
                    h = (h * 32'd31) ^ {24'd0, b[8*i +: 8]};
            end
            return h % SLOTS;
        endfunction

        // Apply one accepted request to the mirror and queue its result
        function void note_request(t_cache_req r);
            t_cache_res        res;
            logic [WORD_W-1:0] b;
            int unsigned       home;
            int unsigned       s;
            int                k;
            bit                found;
            res.hit    = 1'b0;
            res.answer = '0;
            b          = r.bin ? r.b : '0;
            if (r.code != CODE_EMPTY) begin
                home = home_of(r.bin, r.code, r.a, b);
                s    = home;
                if (r.op == OP_LOOKUP) begin
                    found = 1'b0;
                    for (k = 0; k < 3 && !found; k++) begin
                        if (code_tab[s] == r.code && first_tab[s] == r.a &&
                            (!r.bin || second_tab[s] == b)) begin
                            res.hit    = 1'b1;
                            res.answer = answer_tab[s];
                            found      = 1'b1;
                        end
                        s = (s + 1) % SLOTS;
                    end
                end else begin
                    // first empty of three, else the home slot
                    k = 0;
                    while (k < 3 && code_tab[s] != CODE_EMPTY) begin
                        s = (s + 1) % SLOTS;
                        k++;
                    end
                    if (k == 3)
                        s = home;
                    code_tab[s]   = r.code;
                    first_tab[s]  = r.a;
                    second_tab[s] = b;
                    answer_tab[s] = r.ans;
                end
            end
            awaited_results.push_back(res);
        endfunction

        // Compare one transferred result with the oldest expectation
        function void check_result(logic hit, logic [WORD_W-1:0] answer);
            t_cache_res e;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result hit=%0b answer=%h", $time, hit, answer);
                mismatches++;
                return;
            end
            e = awaited_results.pop_front();
            if (hit !== e.hit) begin
                $display("%0t: hit mismatch expected %0b actual %0b", $time, e.hit, hit);
                mismatches++;
            end
            if (answer !== e.answer) begin
                $display("%0t: answer mismatch expected %h actual %h",
                         $time, e.answer, answer);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    cache_mirror mirror;
    bit          calm;      // no idling on either side
    bit          rx_hold;   // request a long receiver hold-off
    int          cycles;
    t_cache_req  key_pool [$];

    hashed_operation_result_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock, 12 ns period
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result checking on every master-side transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            mirror.check_result(o_m_axis_tuser[0], o_m_axis_tdata);
    end

    // Receiver back-pressure: random stalls, one long hold-off on request
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
            end else begin
                i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // Random key whose home slot lies in [target, target + span)
    function automatic t_cache_req find_key(int unsigned target, int unsigned span, logic bin);
        t_cache_req  r;
        int unsigned gap;
        r.op  = OP_LOOKUP;
        r.bin = bin;
        r.ans = '0;
        do begin
            r.code = CODE_W'($urandom_range(1, 255));
            r.a    = $urandom;
            r.b    = bin ? $urandom : '0;
            gap    = (cache_mirror::home_of(bin, r.code, r.a, r.b) + SLOTS - target) % SLOTS;
        end while (gap >= span);
        return r;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_req(t_cache_req r);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 12) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r.ans, r.b, r.a, r.code};
        i_s_axis_tuser  <= {r.bin, r.op};
        do @(posedge i_clk); while (!(o_s_axis_tready && i_rst_n));
        mirror.note_request(r);
    endtask

    // Sender pause until every result is back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_cache_req r;
        t_cache_req k;
        t_cache_req directed [$];
        t_cache_req wrap_keys [4];
        int unsigned tgt;
        int          i;
        int          j;
        int          pick;

        mirror          = new();
        cycles          = 0;
        calm            = 1'b0;
        rx_hold         = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, code zero, field extremes
        r = '{OP_LOOKUP, 1'b1, 8'd255, 32'hffffffff, 32'hffffffff, 32'hffffffff};
        directed.push_back(r);
        r = '{OP_INSERT, 1'b1, CODE_EMPTY, 32'h0, 32'h0, 32'hffffffff};
        directed.push_back(r);
        r.op = OP_LOOKUP;
        directed.push_back(r);
        // unary insert, lookup with a different (ignored) second operand
        r = '{OP_INSERT, 1'b0, 8'd1, 32'h0, 32'h12345678, 32'hffffffff};
        directed.push_back(r);
        r = '{OP_LOOKUP, 1'b0, 8'd1, 32'h0, 32'hffffffff, 32'h0};
        directed.push_back(r);
        // binary key at the extremes, then same key with another second operand
        r = '{OP_INSERT, 1'b1, 8'd255, 32'hffffffff, 32'hffffffff, 32'h0};
        directed.push_back(r);
        r.op = OP_LOOKUP;
        directed.push_back(r);
        r.b = 32'h0;
        directed.push_back(r);
        // four keys homed at the last slot: probes wrap, the fourth overwrites home
        for (i = 0; i < 4; i++) begin
            wrap_keys[i]     = find_key(SLOTS - 1, 1, i[0]);
            wrap_keys[i].op  = OP_INSERT;
            wrap_keys[i].ans = $urandom;
            directed.push_back(wrap_keys[i]);
        end
        for (i = 0; i < 4; i++) begin
            r    = wrap_keys[i];
            r.op = OP_LOOKUP;
            directed.push_back(r);
        end
        // code zero insert must leave the table alone
        r = wrap_keys[3];
        r.code = CODE_EMPTY;
        r.op   = OP_INSERT;
        directed.push_back(r);
        r = wrap_keys[3];
        r.op = OP_LOOKUP;
        directed.push_back(r);

        foreach (directed[n])
            send_req(directed[n]);
        wait_for_results();

        // Key pool: clusters around a few slots (one at the table end) plus loose keys
        for (i = 0; i < 8; i++) begin
            tgt = (i == 0) ? SLOTS - 2 : $urandom_range(0, SLOTS - 1);
            for (j = 0; j < 5; j++)
                key_pool.push_back(find_key(tgt, 3, 1'($urandom_range(0, 1))));
        end
        for (i = 0; i < 32; i++) begin
            k.op   = OP_LOOKUP;
            k.bin  = 1'($urandom_range(0, 1));
            k.code = CODE_W'($urandom_range(1, 255));
            k.a    = $urandom;
            k.b    = k.bin ? $urandom : '0;
            k.ans  = '0;
            key_pool.push_back(k);
        end

        // Random requests
        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i == 300)
                rx_hold = 1'b1;
            if (i == 800)
                wait_for_results();
            calm = (i >= 1000 && i < 1300);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                // pool key, random answer; unary keys get a random ignored operand
                r     = key_pool[$urandom_range(0, key_pool.size() - 1)];
                r.op  = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
                r.ans = $urandom;
                if (!r.bin)
                    r.b = $urandom;
            end else if (pick < 90) begin
                // broken key: other key kind or altered second operand
                r     = key_pool[$urandom_range(0, key_pool.size() - 1)];
                r.op  = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_LOOKUP;
                r.ans = $urandom;
                if ($urandom_range(0, 1))
                    r.bin = ~r.bin;
                else
                    r.b = r.b ^ (32'h1 << $urandom_range(0, 31));
            end else begin
                // noise over the whole field space, code zero now and then
                r.op   = 1'($urandom_range(0, 1));
                r.bin  = 1'($urandom_range(0, 1));
                r.code = ($urandom_range(0, 9) == 0) ? CODE_EMPTY
                                                     : CODE_W'($urandom_range(0, 255));
                r.a    = $urandom;
                r.b    = $urandom;
                r.ans  = $urandom;
            end
            send_req(r);
        end
        calm = 1'b0;

        // Drain and let the pipeline settle
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/hocc_pkg.sv
hdl/hocc_ram.sv
hdl/hashed_operation_result_cache.sv
hdl/hocc_checker.sv
dv/hashed_operation_result_cache_tb.sv
